FILE: rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and codes for the reserved range table: field widths, status
// codes, action codes and the token that walks down the chain of cells.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // Fixed widths of the beat fields.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned MODE_W    = 2;

  // Action codes of a request beat.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Status codes of a response beat.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd4;

  // Token modes.
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Control part of the token handed from cell to cell. The range it carries
  // travels beside it on separate buses, as its width is a module parameter.
  typedef struct packed {
    logic                vld;
    logic [MODE_W-1:0]   mode;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [IDX_W-1:0]    idx;
  } rrt_tok_t;

endpackage

FILE: rtl/rrt_req_if.sv
// ----------------------------------------------------------------------------
// rrt_req_if
// Request channel of the reserved range table: one beat is an insert or a read.
// ----------------------------------------------------------------------------
interface rrt_req_if;
  import rrt_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [DATA_W-1:0]   start_addr;
  logic [DATA_W-1:0]   end_addr;
  logic [IDX_W-1:0]    read_index;

  modport source (
    output valid, action, start_addr, end_addr, read_index,
    input  ready
  );

  modport sink (
    input  valid, action, start_addr, end_addr, read_index,
    output ready
  );

endinterface

FILE: rtl/rrt_rsp_if.sv
// ----------------------------------------------------------------------------
// rrt_rsp_if
// Response channel of the reserved range table: one beat per request beat.
// ----------------------------------------------------------------------------
interface rrt_rsp_if;
  import rrt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [DATA_W-1:0]    entry_start;
  logic [DATA_W-1:0]    entry_end;
  logic                 entry_valid;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, status, entry_start, entry_end, entry_valid, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, entry_start, entry_end, entry_valid, entry_count,
    output ready
  );

endinterface

FILE: rtl/rrt_cell.sv
// ----------------------------------------------------------------------------
// rrt_cell
// One table slot. It holds one range and, when the token passes, searches,
// merges, inserts, shifts or reads, then hands the token to the next cell.
// ----------------------------------------------------------------------------
module rrt_cell #(
  parameter int unsigned RANGES    = 16,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(RANGES+1)-1:0]      count_i,
  input  rrt_pkg::rrt_tok_t                tok_i,
  input  logic [ADDR_BITS-1:0]             lo_i,
  input  logic [ADDR_BITS-1:0]             hi_i,
  output rrt_pkg::rrt_tok_t                tok_o,
  output logic [ADDR_BITS-1:0]             lo_o,
  output logic [ADDR_BITS-1:0]             hi_o
);
  import rrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(RANGES + 1);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(RANGES);
  // Only cells whose position fits the read index field can be read.
  localparam bit IDX_REACH = CELL_IDX < (1 << IDX_W);

  rrt_tok_t             tok_d, tok_q;
  logic [ADDR_BITS-1:0] lo_d, lo_q, hi_d, hi_q;
  logic [ADDR_BITS-1:0] start_d, start_q, end_d, end_q;
  logic                 ent_we;
  logic                 occupied;
  logic                 full;

  assign occupied = IDX_C < count_i;
  assign full     = count_i == FULL_C;

  // Work of the cell on the token that passes through it this cycle.
  always_comb begin
    tok_d   = tok_i;
    lo_d    = lo_i;
    hi_d    = hi_i;
    ent_we  = 1'b0;
    start_d = lo_i;
    end_d   = hi_i;
    if (tok_i.vld) begin
      case (tok_i.mode)
        MODE_SEARCH: begin
          if (occupied) begin
            if (hi_i < start_q) begin
              if (full) begin
                tok_d.mode   = MODE_DONE;
                tok_d.status = ST_FULL;
              end else begin
                // Take the new range here and carry the old one onward.
                ent_we     = 1'b1;
                lo_d       = start_q;
                hi_d       = end_q;
                tok_d.mode = MODE_SHIFT;
              end
            end else if (lo_i > end_q) begin
              // Lies wholly above this entry: keep looking.
              tok_d.mode = MODE_SEARCH;
            end else begin
              ent_we       = 1'b1;
              start_d      = (lo_i < start_q) ? lo_i : start_q;
              end_d        = (hi_i > end_q) ? hi_i : end_q;
              tok_d.mode   = MODE_DONE;
              tok_d.status = ST_MERGED;
            end
          end else begin
            // First free slot: append at the tail.
            ent_we       = 1'b1;
            tok_d.mode   = MODE_DONE;
            tok_d.status = ST_INSERTED;
          end
        end
        MODE_SHIFT: begin
          ent_we = 1'b1;
          lo_d   = start_q;
          hi_d   = end_q;
          if (IDX_C == count_i) begin
            tok_d.mode   = MODE_DONE;
            tok_d.status = ST_INSERTED;
          end
        end
        MODE_READ: begin
          if (IDX_REACH && occupied && (tok_i.idx == IDX_W'(CELL_IDX))) begin
            lo_d      = start_q;
            hi_d      = end_q;
            tok_d.hit = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // Token control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Range carried with the token, and the entry held by this cell.
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (ent_we) begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign tok_o = tok_q;
  assign lo_o  = lo_q;
  assign hi_o  = hi_q;

endmodule

FILE: rtl/reserved_range_table.sv
// ----------------------------------------------------------------------------
// reserved_range_table
// Sorted table of reserved address ranges with insert-with-merge and read.
// ----------------------------------------------------------------------------
// Each read or valid insert beat launches a token down a chain of RANGES
// cells, one cell per cycle; each cell holds one range and inserts, merges,
// shifts or reads as the token passes. An insert or read gives its response
// beat through the pending slot and the output register, and a new request
// is taken once the previous result has left the pending slot, so no new
// request is taken while a token walks the chain. An insert whose end is not
// above its start is answered as invalid without touching the table.
// A response may wait on the output while the next request is accepted.
// Table contents are not cleared at reset; only the entry count is.
module reserved_range_table #(
  parameter int unsigned RANGES    = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrt_req_if.sink   req_i,
  rrt_rsp_if.source rsp_o
);
  import rrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(RANGES + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(RANGES);

  // Chain buses: element k feeds cell k, element RANGES is the tail.
  rrt_tok_t             tok_w [RANGES+1];
  logic [ADDR_BITS-1:0] lo_w  [RANGES+1];
  logic [ADDR_BITS-1:0] hi_w  [RANGES+1];

  rrt_tok_t             launch_d, launch_q;
  logic [ADDR_BITS-1:0] launch_lo_d, launch_lo_q, launch_hi_d, launch_hi_q;
  logic                 busy_d, busy_q;
  logic [CNT_W-1:0]     count_d, count_q;

  logic                 pend_vld_d, pend_vld_q;
  logic [STATUS_W-1:0]  pend_status_d, pend_status_q;
  logic [DATA_W-1:0]    pend_start_d, pend_start_q, pend_end_d, pend_end_q;
  logic                 pend_ev_d, pend_ev_q;
  logic [CNT_W-1:0]     pend_cnt_d, pend_cnt_q;

  logic                 out_vld_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [DATA_W-1:0]    out_start_q, out_end_q;
  logic                 out_ev_q;
  logic [CNT_W-1:0]     out_cnt_q;

  logic                 accept;
  logic                 out_load;
  logic [ADDR_BITS-1:0] req_lo, req_hi;
  rrt_tok_t             tail;
  logic [STATUS_W-1:0]  tail_status;
  logic                 tail_read;

  assign req_lo = ADDR_BITS'(req_i.start_addr);
  assign req_hi = ADDR_BITS'(req_i.end_addr);

  assign req_i.ready = !busy_q && !pend_vld_q;
  assign accept      = req_i.valid && req_i.ready;

  assign tail        = tok_w[RANGES];
  assign tail_read   = tail.mode == MODE_READ;
  // A search that runs off the end found no slot in a full table.
  assign tail_status = (tail.mode == MODE_SEARCH) ? ST_FULL : tail.status;

  // Launch, completion and the pending result slot.
  always_comb begin
    launch_d      = '0;
    launch_lo_d   = req_lo;
    launch_hi_d   = req_hi;
    busy_d        = busy_q;
    count_d       = count_q;
    pend_vld_d    = pend_vld_q;
    pend_status_d = pend_status_q;
    pend_start_d  = pend_start_q;
    pend_end_d    = pend_end_q;
    pend_ev_d     = pend_ev_q;
    pend_cnt_d    = pend_cnt_q;

    if (out_load) begin
      pend_vld_d = 1'b0;
    end

    if (accept) begin
      if (req_i.action == ACT_READ) begin
        launch_d.vld    = 1'b1;
        launch_d.mode   = MODE_READ;
        launch_d.status = ST_READ;
        launch_d.idx    = req_i.read_index;
        launch_lo_d     = '0;
        launch_hi_d     = '0;
        busy_d          = 1'b1;
      end else if (req_hi <= req_lo) begin
        pend_vld_d    = 1'b1;
        pend_status_d = ST_INVALID;
        pend_start_d  = '0;
        pend_end_d    = '0;
        pend_ev_d     = 1'b0;
        pend_cnt_d    = count_q;
      end else begin
        launch_d.vld    = 1'b1;
        launch_d.mode   = MODE_SEARCH;
        launch_d.status = ST_INSERTED;
        busy_d          = 1'b1;
      end
    end

    if (tail.vld) begin
      busy_d = 1'b0;
      if (!tail_read && (tail_status == ST_INSERTED)) begin
        count_d = count_q + 1'b1;
      end
      pend_vld_d    = 1'b1;
      pend_status_d = tail_status;
      pend_ev_d     = tail_read && tail.hit;
      pend_start_d  = (tail_read && tail.hit) ? DATA_W'(lo_w[RANGES]) : '0;
      pend_end_d    = (tail_read && tail.hit) ? DATA_W'(hi_w[RANGES]) : '0;
      pend_cnt_d    = count_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q   <= '0;
      busy_q     <= 1'b0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      launch_q   <= launch_d;
      busy_q     <= busy_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Launch range and pending result payload.
  always_ff @(posedge clk_i) begin
    launch_lo_q   <= launch_lo_d;
    launch_hi_q   <= launch_hi_d;
    pend_status_q <= pend_status_d;
    pend_start_q  <= pend_start_d;
    pend_end_q    <= pend_end_d;
    pend_ev_q     <= pend_ev_d;
    pend_cnt_q    <= pend_cnt_d;
  end

  // Output register: filled from the pending slot whenever it is free.
  assign out_load = pend_vld_q && (!out_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_start_q  <= pend_start_q;
      out_end_q    <= pend_end_q;
      out_ev_q     <= pend_ev_q;
      out_cnt_q    <= pend_cnt_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_start = out_start_q;
  assign rsp_o.entry_end   = out_end_q;
  assign rsp_o.entry_valid = out_ev_q;
  assign rsp_o.entry_count = CNT_OUT_W'(out_cnt_q);

  // Chain of cells.
  assign tok_w[0] = launch_q;
  assign lo_w[0]  = launch_lo_q;
  assign hi_w[0]  = launch_hi_q;

  for (genvar g = 0; g < RANGES; g++) begin : g_cell
    rrt_cell #(
      .RANGES    (RANGES),
      .ADDR_BITS (ADDR_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok_w[g]),
      .lo_i    (lo_w[g]),
      .hi_i    (hi_w[g]),
      .tok_o   (tok_w[g+1]),
      .lo_o    (lo_w[g+1]),
      .hi_o    (hi_w[g+1])
    );
  end

  // The table never holds more than RANGES entries.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_C)
    else $error("entry count above table size");

  // The count only ever grows by one per completed insert.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count changed by more than one");

  // A token leaves the chain only after walking every cell from its launch.
  a_tail_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> $past(launch_q.vld, RANGES))
    else $error("token left the chain at the wrong time");

  // A shift always finds a free slot inside the chain.
  a_no_tail_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (tail.mode != MODE_SHIFT))
    else $error("shift ran off the end of the chain");

  // While a token walks, no result is pending.
  a_busy_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pend_vld_q)
    else $error("pending result while the chain is busy");

  // Only a read response reports a valid entry.
  a_ev_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.entry_valid) |-> (rsp_o.status == ST_READ))
    else $error("valid entry on an insert response");

endmodule
